// File: rtl/datagram_sequence_reassembler_macros.svh
// ---------------------------------------------------------------------------
// Datagram sequence reassembler assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DATAGRAM_SEQUENCE_REASSEMBLER_MACROS_SVH
`define DATAGRAM_SEQUENCE_REASSEMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dsr_pkg.sv
// ---------------------------------------------------------------------------
// Datagram sequence reassembler package
// Status codes, register indexes and the result record.
// ---------------------------------------------------------------------------
package dsr_pkg;

    typedef enum logic [2:0] {
        ST_WHOLE   = 3'd0,
        ST_REASM   = 3'd1,
        ST_ORDER   = 3'd2,
        ST_GAP     = 3'd3,
        ST_ILLEGAL = 3'd4,
        ST_STORED  = 3'd5,
        ST_LARGE   = 3'd6
    } t_status;

    localparam logic [0:0] CFG_FRAG_BUF_SIZE = 1'b0;
    localparam logic [0:0] CFG_MAX_MSG_SIZE  = 1'b1;

    localparam logic [17:0] CFG_RESET_VALUE = 18'h20000;
    localparam logic [17:0] SEQ_BYTES       = 18'd4;

    typedef struct packed {
        t_status     status;
        logic        deliver;
        logic [30:0] dropped_count;
        logic [17:0] write_offset;
        logic [17:0] message_length;
    } t_result;

endpackage

// File: rtl/dsr_core.sv
// ---------------------------------------------------------------------------
// Datagram sequence reassembler decision core
// Holds the sequence and reassembly state and decides one header per cycle in which i_fire is high.
// ---------------------------------------------------------------------------
module dsr_core #(
    parameter int FRAG_SIZE     = 1300,
    parameter int BUF_BYTES_MAX = 131072
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [30:0]          i_sequence_req,
    input  logic                 i_fragmented,
    input  logic signed [31:0]   i_fragment_start,
    input  logic signed [15:0]   i_fragment_length,
    input  logic [15:0]          i_payload_remaining,
    input  logic [17:0]          i_cfg_buf_size,
    input  logic [17:0]          i_cfg_max_msg,
    output dsr_pkg::t_result     o_result
);

    logic [30:0] r_last;
    logic [30:0] r_owner;
    logic [17:0] r_asm;
    logic [30:0] r_held;
    logic [30:0] n_last;
    logic [30:0] n_owner;
    logic [17:0] n_asm;
    logic [30:0] n_held;

    logic        out_of_order;
    logic [30:0] skipped;
    logic        owner_new;
    logic [17:0] eff_asm;
    logic        gap_hit;
    logic [15:0] flen_mag;
    logic [18:0] sum;
    logic        over_buf;
    logic        over_cfg;
    logic        illegal;
    logic [17:0] new_asm;
    logic        is_full;
    logic        too_large;
    dsr_pkg::t_status status;

    assign out_of_order = (i_sequence_req <= r_last);
    assign skipped      = i_sequence_req - r_last - 31'd1;
    assign owner_new    = (i_sequence_req != r_owner);
    assign eff_asm      = owner_new ? 18'd0 : r_asm;
    assign gap_hit      = (i_fragment_start != {14'd0, eff_asm});
    assign flen_mag     = {1'b0, i_fragment_length[14:0]};
    assign sum          = {1'b0, eff_asm} + {4'd0, i_fragment_length[14:0]};
    assign over_buf     = ({13'd0, sum} > 32'(BUF_BYTES_MAX));
    assign over_cfg     = (sum > {1'b0, i_cfg_buf_size});
    assign illegal      = i_fragment_length[15] || (flen_mag > i_payload_remaining)
                          || over_buf || over_cfg;
    assign new_asm      = sum[17:0];
    assign is_full      = (i_fragment_length == 16'(FRAG_SIZE));
    assign too_large    = (new_asm > i_cfg_max_msg);

    always_comb begin
        n_last  = r_last;
        n_owner = r_owner;
        n_asm   = r_asm;
        n_held  = r_held;
        status  = dsr_pkg::ST_ORDER;
        o_result.write_offset   = 18'd0;
        o_result.message_length = 18'd0;
        if (!out_of_order) begin
            n_held = skipped;
            if (!i_fragmented) begin
                n_last = i_sequence_req;
                status = dsr_pkg::ST_WHOLE;
            end else begin
                n_owner = i_sequence_req;
                n_asm   = eff_asm;
                if (gap_hit) begin
                    status = dsr_pkg::ST_GAP;
                end else if (illegal) begin
                    status = dsr_pkg::ST_ILLEGAL;
                end else begin
                    o_result.write_offset = eff_asm;
                    n_asm = new_asm;
                    if (is_full) begin
                        status = dsr_pkg::ST_STORED;
                    end else if (too_large) begin
                        status = dsr_pkg::ST_LARGE;
                    end else begin
                        status = dsr_pkg::ST_REASM;
                        o_result.message_length = new_asm + dsr_pkg::SEQ_BYTES;
                        n_asm  = 18'd0;
                        n_last = i_sequence_req;
                    end
                end
            end
        end
        o_result.status        = status;
        o_result.deliver       = (status == dsr_pkg::ST_WHOLE) || (status == dsr_pkg::ST_REASM);
        o_result.dropped_count = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_owner <= '0;
            r_asm   <= '0;
            r_held  <= '0;
        end else if (i_fire) begin
            r_last  <= n_last;
            r_owner <= n_owner;
            r_asm   <= n_asm;
            r_held  <= n_held;
        end
    end

endmodule

// File: rtl/datagram_sequence_reassembler.sv
// ---------------------------------------------------------------------------
// Datagram sequence reassembler
// Sequence check and fragment reassembly bookkeeping for parsed packet headers.
// ---------------------------------------------------------------------------
// The input channel takes one parsed header per transfer; the output channel
// gives exactly one result per header, in order. Both use valid and ready.
// A header transfer lands in the input register; once the result register can
// load, the decision core updates the sequence and reassembly state and fills
// the result register, which offers the result on the output channel.
// One header per cycle is sustained while the receiver takes each result; the
// rate is set by the single state update per cycle in the decision core.
// When the receiver stalls, the result register holds its transfer and the
// input register takes one more header before ready drops.
// The configuration channel is always ready; index 0 sets the reassembly
// buffer capacity and index 1 the largest deliverable message. Write it only
// while no header is in flight.
// Synchronous reset empties both registers, clears the decision core state to
// zero and sets both configuration registers to 131072.
// ---------------------------------------------------------------------------
module datagram_sequence_reassembler #(
    parameter int FRAG_SIZE     = 1300,
    parameter int BUF_BYTES_MAX = 131072
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [30:0]          i_sequence_req,
    input  logic                 i_fragmented,
    input  logic signed [31:0]   i_fragment_start,
    input  logic signed [15:0]   i_fragment_length,
    input  logic [15:0]          i_payload_remaining,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic                 o_deliver,
    output logic [30:0]          o_dropped_count,
    output logic [17:0]          o_write_offset,
    output logic [17:0]          o_message_length,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_index,
    input  logic [17:0]          i_cfg_data
);

    logic                r_in_valid;
    logic [30:0]         r_seq;
    logic                r_frag;
    logic signed [31:0]  r_start;
    logic signed [15:0]  r_flen;
    logic [15:0]         r_remaining;
    logic                r_out_valid;
    dsr_pkg::t_result    r_res;
    logic [17:0]         r_cfg_buf;
    logic [17:0]         r_cfg_max;

    logic                out_load;
    logic                fire;
    dsr_pkg::t_result    core_res;

    assign out_load   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || out_load;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_seq       <= i_sequence_req;
            r_frag      <= i_fragmented;
            r_start     <= i_fragment_start;
            r_flen      <= i_fragment_length;
            r_remaining <= i_payload_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_buf <= dsr_pkg::CFG_RESET_VALUE;
            r_cfg_max <= dsr_pkg::CFG_RESET_VALUE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dsr_pkg::CFG_FRAG_BUF_SIZE: r_cfg_buf <= i_cfg_data;
                dsr_pkg::CFG_MAX_MSG_SIZE:  r_cfg_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsr_core #(
        .FRAG_SIZE     (FRAG_SIZE),
        .BUF_BYTES_MAX (BUF_BYTES_MAX)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire              (fire),
        .i_sequence_req      (r_seq),
        .i_fragmented        (r_frag),
        .i_fragment_start    (r_start),
        .i_fragment_length   (r_flen),
        .i_payload_remaining (r_remaining),
        .i_cfg_buf_size      (r_cfg_buf),
        .i_cfg_max_msg       (r_cfg_max),
        .o_result            (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_res.status;
    assign o_deliver        = r_res.deliver;
    assign o_dropped_count  = r_res.dropped_count;
    assign o_write_offset   = r_res.write_offset;
    assign o_message_length = r_res.message_length;

endmodule

// File: rtl/dsr_checker.sv
// ---------------------------------------------------------------------------
// Datagram sequence reassembler port checker
// Checks result consistency and the output handshake on the top-level ports.
// ---------------------------------------------------------------------------
`include "datagram_sequence_reassembler_macros.svh"

module dsr_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic [2:0]           o_status,
    input  logic                 o_deliver,
    input  logic [30:0]          o_dropped_count,
    input  logic [17:0]          o_write_offset,
    input  logic [17:0]          o_message_length
);

    `DSR_ASSERT_IMP(a_deliver_code, i_clk, i_rst_n, o_out_valid,
        o_deliver == ((o_status == dsr_pkg::ST_WHOLE) || (o_status == dsr_pkg::ST_REASM)),
        "deliver flag disagrees with status")

    `DSR_ASSERT_IMP(a_length_only_reasm, i_clk, i_rst_n,
        o_out_valid && (o_status != dsr_pkg::ST_REASM), o_message_length == 18'd0,
        "message length given for a result that is not reassembled")

    `DSR_ASSERT_IMP(a_offset_codes, i_clk, i_rst_n,
        o_out_valid && (o_status != dsr_pkg::ST_REASM) && (o_status != dsr_pkg::ST_STORED)
            && (o_status != dsr_pkg::ST_LARGE), o_write_offset == 18'd0,
        "write offset given for a rejected or whole packet")

    `DSR_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_dropped_count)
            && $stable(o_write_offset) && $stable(o_message_length),
        "stalled result transfer changed")

endmodule

bind datagram_sequence_reassembler dsr_checker u_dsr_checker (.*);
